// ===== hw/rtl/i2c_master_byte_engine_defines.svh =====
// ----------------------------------------------------------------------------
// I2C master byte engine: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// An expression that must hold at every clock edge out of reset.
`define I2CMBE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// A consequent that must hold in the cycle after the antecedent.
`define I2CMBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/i2cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Sequencer phase codes, command codes and configuration register indices.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int unsigned NumPhases = 21;

  typedef enum logic [NumPhases-1:0] {
    PH_IDLE = 21'b000000000000000000001,
    PH_S_A  = 21'b000000000000000000010,
    PH_S_B  = 21'b000000000000000000100,
    PH_P_A  = 21'b000000000000000001000,
    PH_P_B  = 21'b000000000000000010000,
    PH_P_C  = 21'b000000000000000100000,
    PH_W_A  = 21'b000000000000001000000,
    PH_W_B  = 21'b000000000000010000000,
    PH_W_C  = 21'b000000000000100000000,
    PH_W_D  = 21'b000000000001000000000,
    PH_W_E  = 21'b000000000010000000000,
    PH_W_F  = 21'b000000000100000000000,
    PH_W_G  = 21'b000000001000000000000,
    PH_W_H  = 21'b000000010000000000000,
    PH_R_A  = 21'b000000100000000000000,
    PH_R_B  = 21'b000001000000000000000,
    PH_R_C  = 21'b000010000000000000000,
    PH_R_D  = 21'b000100000000000000000,
    PH_R_E  = 21'b001000000000000000000,
    PH_R_F  = 21'b010000000000000000000,
    PH_R_G  = 21'b100000000000000000000
  } phase_e;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_STOP  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_READ  = 3'd3,
    MODE_TICK  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CFG_SHORT_TICKS = 2'd0,
    CFG_LONG_TICKS  = 2'd1,
    CFG_WAIT_TICKS  = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] MsbMask      = 8'h80;
  localparam logic [3:0] BitsPerByte  = 4'd8;
  localparam logic [15:0] ShortReset  = 16'd1;
  localparam logic [15:0] LongReset   = 16'd4;
  localparam logic [15:0] WaitReset   = 16'd1;

endpackage

// ===== hw/rtl/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine
// Bit-level I2C master sequencer for start, stop, byte write and byte read.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+------------------------------
//  input    | in        | in_valid_i/in_ready_o  | mode, data_byte, send_ack, sda_in
//  result   | out       | out_valid_o/out_ready_i| scl, sda, busy, done, ack, read
//  config   | in        | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
//  The sequencer state advances once per accepted beat and the result is
//  captured in the output register on the same edge. The input side stays
//  ready whenever the output register is empty or is being emptied in the same
//  cycle, so beats flow back to back under full throughput. A stall on the
//  result side holds the result and backs up the input side. Reset is
//  asynchronous and active low; it idles the sequencer with both lines released
//  and loads the delay registers with their default counts.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_defines.svh"

module i2c_master_byte_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   mode_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         send_ack_i,
  input  logic                         sda_in_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         scl_out_o,
  output logic                         sda_out_o,
  output logic                         busy_res_o,
  output logic                         done_res_o,
  output logic                         ack_seen_o,
  output logic [7:0]                   read_data_o,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  i2cmbe_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [15:0]                  cfg_wdata_i
);
  import i2cmbe_pkg::*;

  // Delay configuration.
  logic [15:0] short_ticks_q, long_ticks_q, wait_ticks_q;

  // Sequencer state.
  phase_e      phase_q, phase_d;
  logic [3:0]  bit_count_q, bit_count_d;
  logic [7:0]  shift_byte_q, shift_byte_d;
  logic [16:0] delay_left_q, delay_left_d;
  logic        ack_flag_q, ack_flag_d;
  logic        want_ack_q, want_ack_d;
  logic        scl_level_q, scl_level_d;
  logic        sda_level_q, sda_level_d;
  logic [7:0]  last_read_q, last_read_d;
  logic        done;

  // Result register.
  logic        out_valid_q;

  logic        accept;
  logic        go;
  phase_e      nxt;
  logic [3:0]  bit_inc;
  logic [16:0] hold_short, hold_long, hold_sw;

  // The output register frees up in the same cycle that its beat is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign hold_short = {1'b0, short_ticks_q};
  assign hold_long  = {1'b0, long_ticks_q};
  assign hold_sw    = {1'b0, short_ticks_q} + {1'b0, wait_ticks_q};
  assign bit_inc    = bit_count_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_ticks_q <= ShortReset;
      long_ticks_q  <= LongReset;
      wait_ticks_q  <= WaitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHORT_TICKS: short_ticks_q <= cfg_wdata_i;
        CFG_LONG_TICKS:  long_ticks_q  <= cfg_wdata_i;
        CFG_WAIT_TICKS:  wait_ticks_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next-state logic. The first part picks whether a new action is entered and
  // which one; the second part performs that action on the lines and loads its
  // hold count. Bit counter and shift register updates made in the first part
  // are seen by the second, as a write action needs the shifted byte.
  always_comb begin
    phase_d      = phase_q;
    bit_count_d  = bit_count_q;
    shift_byte_d = shift_byte_q;
    delay_left_d = delay_left_q;
    ack_flag_d   = ack_flag_q;
    want_ack_d   = want_ack_q;
    scl_level_d  = scl_level_q;
    sda_level_d  = sda_level_q;
    last_read_d  = last_read_q;
    done         = 1'b0;
    go           = 1'b0;
    nxt          = PH_IDLE;

    if (accept) begin
      if (phase_q == PH_IDLE) begin
        // A tick or an unused mode code leaves an idle sequencer alone.
        bit_count_d = 4'd0;
        case (mode_i)
          MODE_START: begin
            go  = 1'b1;
            nxt = PH_S_A;
          end
          MODE_STOP: begin
            go  = 1'b1;
            nxt = PH_P_A;
          end
          MODE_WRITE: begin
            go           = 1'b1;
            nxt          = PH_W_A;
            shift_byte_d = data_byte_i;
          end
          MODE_READ: begin
            go           = 1'b1;
            nxt          = PH_R_A;
            shift_byte_d = 8'd0;
            want_ack_d   = send_ack_i;
          end
          default: bit_count_d = bit_count_q;
        endcase
      end else if (delay_left_q != 17'd0) begin
        // Commands that arrive while busy count as ticks.
        delay_left_d = delay_left_q - 17'd1;
      end else begin
        go = 1'b1;
        case (phase_q)
          PH_S_A: nxt = PH_S_B;
          PH_P_A: nxt = PH_P_B;
          PH_P_B: nxt = PH_P_C;
          PH_W_A: nxt = PH_W_B;
          PH_W_B: nxt = PH_W_C;
          PH_W_C: begin
            shift_byte_d = shift_byte_q << 1;
            bit_count_d  = bit_inc;
            nxt          = (bit_inc >= BitsPerByte) ? PH_W_D : PH_W_A;
          end
          PH_W_D: nxt = PH_W_E;
          PH_W_E: nxt = PH_W_F;
          PH_W_F: nxt = PH_W_G;
          PH_W_G: begin
            ack_flag_d = !sda_in_i;
            nxt        = PH_W_H;
          end
          PH_R_A: nxt = PH_R_B;
          PH_R_B: begin
            shift_byte_d = {shift_byte_q[6:0], sda_in_i};
            bit_count_d  = bit_inc;
            if (bit_inc >= BitsPerByte) begin
              last_read_d = {shift_byte_q[6:0], sda_in_i};
              nxt         = PH_R_C;
            end else begin
              nxt = PH_R_A;
            end
          end
          PH_R_C: nxt = want_ack_q ? PH_R_D : PH_R_E;
          PH_R_D: nxt = PH_R_E;
          PH_R_E: nxt = PH_R_F;
          PH_R_F: nxt = PH_R_G;
          default: begin
            // The last action of a list has run out: the sequence ends.
            go           = 1'b0;
            phase_d      = PH_IDLE;
            delay_left_d = 17'd0;
            done         = 1'b1;
          end
        endcase
      end
    end

    if (go) begin
      phase_d = nxt;
      case (nxt)
        PH_S_A: begin scl_level_d = 1'b1; delay_left_d = hold_long;  end
        PH_S_B: begin sda_level_d = 1'b0; delay_left_d = hold_long;  end
        PH_P_A: begin sda_level_d = 1'b0; delay_left_d = hold_long;  end
        PH_P_B: begin scl_level_d = 1'b1; delay_left_d = hold_short; end
        PH_P_C: begin sda_level_d = 1'b1; delay_left_d = hold_long;  end
        PH_W_A: begin scl_level_d = 1'b0; delay_left_d = hold_short; end
        PH_W_B: begin
          sda_level_d  = (shift_byte_d & MsbMask) != 8'd0;
          delay_left_d = hold_short;
        end
        PH_W_C: begin scl_level_d = 1'b1; delay_left_d = hold_sw;    end
        PH_W_D: begin scl_level_d = 1'b0; delay_left_d = hold_short; end
        PH_W_E: begin sda_level_d = 1'b1; delay_left_d = hold_long;  end
        PH_W_F: begin scl_level_d = 1'b1; delay_left_d = hold_long;  end
        PH_W_G: begin sda_level_d = 1'b1; delay_left_d = hold_long;  end
        PH_W_H: begin scl_level_d = 1'b0; delay_left_d = hold_long;  end
        PH_R_A: begin
          // SDA is released only on the first bit of the byte.
          if (bit_count_d == 4'd0) begin
            sda_level_d = 1'b1;
          end
          scl_level_d  = 1'b0;
          delay_left_d = hold_short;
        end
        PH_R_B: begin scl_level_d = 1'b1; delay_left_d = hold_sw; end
        PH_R_C: begin
          scl_level_d  = 1'b0;
          sda_level_d  = 1'b1;
          delay_left_d = hold_long;
        end
        PH_R_D: begin sda_level_d = 1'b0; delay_left_d = hold_long; end
        PH_R_E: begin scl_level_d = 1'b1; delay_left_d = hold_long; end
        PH_R_F: begin scl_level_d = 1'b0; delay_left_d = hold_long; end
        PH_R_G: begin sda_level_d = 1'b1; delay_left_d = 17'd0;     end
        default: begin
          phase_d      = PH_IDLE;
          delay_left_d = 17'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_count_q  <= 4'd0;
      shift_byte_q <= 8'd0;
      delay_left_q <= 17'd0;
      ack_flag_q   <= 1'b0;
      want_ack_q   <= 1'b0;
      scl_level_q  <= 1'b1;
      sda_level_q  <= 1'b1;
      last_read_q  <= 8'd0;
    end else begin
      phase_q      <= phase_d;
      bit_count_q  <= bit_count_d;
      shift_byte_q <= shift_byte_d;
      delay_left_q <= delay_left_d;
      ack_flag_q   <= ack_flag_d;
      want_ack_q   <= want_ack_d;
      scl_level_q  <= scl_level_d;
      sda_level_q  <= sda_level_d;
      last_read_q  <= last_read_d;
    end
  end

  // Result register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      scl_out_o   <= scl_level_d;
      sda_out_o   <= sda_level_d;
      busy_res_o  <= phase_d != PH_IDLE;
      done_res_o  <= done;
      ack_seen_o  <= ack_flag_d;
      read_data_o <= last_read_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A finished sequence always reports the engine as no longer busy.
  `I2CMBE_ASSERT_ALWAYS(a_done_not_busy, !(out_valid_q && done_res_o && busy_res_o),
                        "done result reported while still busy")
  // An idle sequencer never carries a pending hold count.
  `I2CMBE_ASSERT_ALWAYS(a_idle_no_delay, (phase_q != PH_IDLE) || (delay_left_q == 17'd0),
                        "hold count left over while idle")
  // The bit counter never runs past one byte.
  `I2CMBE_ASSERT_ALWAYS(a_bit_count_range, bit_count_q <= BitsPerByte,
                        "bit counter out of range")
  // A beat that finds a pending hold only counts it down.
  `I2CMBE_ASSERT_NEXT(a_hold_countdown,
                      accept && (phase_q != PH_IDLE) && (delay_left_q != 17'd0),
                      (delay_left_q == $past(delay_left_q) - 17'd1) &&
                      (phase_q == $past(phase_q)),
                      "hold countdown did not step by one")

endmodule

// ===== tb/tb_i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// Testbench for the I2C master byte engine
// Drives start, stop, byte write and byte read commands interleaved with tick
// beats. A cycle-free line model predicts SCL, SDA, busy, done, the slave
// acknowledge and the read byte for every accepted beat, and each result beat
// is checked against the oldest prediction. Both channels idle and stall at
// random, the delay registers are swept through several settings including
// zero, and the result side is held off once for long enough to back the
// block up.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmbe_pkg::*;

  // Mode codes that the block does not decode; they act as ticks.
  localparam logic [2:0] ModeUnusedLo = 3'd5;
  localparam logic [2:0] ModeUnusedHi = 3'd7;

  // How the SDA level seen by the block is chosen for tick beats.
  localparam int SdaLow    = 0;
  localparam int SdaHigh   = 1;
  localparam int SdaRandom = 2;

  localparam int HoldOffCycles = 400;
  localparam int StallLimit    = 4000;

  // One result beat: the line levels and status after an accepted input beat.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       ack;
    logic [7:0] rd_byte;
  } line_beat_t;

  // Tracks the sequencer as the commands go in and holds the line levels that
  // each accepted beat must produce, oldest first.
  class i2c_line_tracker;
    logic [15:0] short_q, long_q, wait_q;
    phase_e      phase_q;
    logic [3:0]  bit_cnt_q;
    logic [7:0]  shift_q;
    logic [16:0] hold_q;
    logic        ack_q, want_ack_q, scl_q, sda_q;
    logic [7:0]  last_read_q;
    line_beat_t  line_levels_q[$];
    int unsigned errors;

    function new();
      short_q     = ShortReset;
      long_q      = LongReset;
      wait_q      = WaitReset;
      phase_q     = PH_IDLE;
      bit_cnt_q   = '0;
      shift_q     = '0;
      hold_q      = '0;
      ack_q       = 1'b0;
      want_ack_q  = 1'b0;
      scl_q       = 1'b1;
      sda_q       = 1'b1;
      last_read_q = '0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_SHORT_TICKS: short_q = val;
        CFG_LONG_TICKS:  long_q = val;
        CFG_WAIT_TICKS:  wait_q = val;
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase_q != PH_IDLE;
    endfunction

    function int pending();
      return line_levels_q.size();
    endfunction

    // Carry out the action of a phase: set the lines and load its hold count.
    function void load_phase(phase_e p);
      logic [16:0] h_short, h_long, h_sw;
      h_short = {1'b0, short_q};
      h_long  = {1'b0, long_q};
      h_sw    = {1'b0, short_q} + {1'b0, wait_q};
      phase_q = p;
      case (p)
        PH_S_A: begin scl_q = 1'b1; hold_q = h_long; end
        PH_S_B: begin sda_q = 1'b0; hold_q = h_long; end
        PH_P_A: begin sda_q = 1'b0; hold_q = h_long; end
        PH_P_B: begin scl_q = 1'b1; hold_q = h_short; end
        PH_P_C: begin sda_q = 1'b1; hold_q = h_long; end
        PH_W_A: begin scl_q = 1'b0; hold_q = h_short; end
        PH_W_B: begin sda_q = |(shift_q & MsbMask); hold_q = h_short; end
        PH_W_C: begin scl_q = 1'b1; hold_q = h_sw; end
        PH_W_D: begin scl_q = 1'b0; hold_q = h_short; end
        PH_W_E: begin sda_q = 1'b1; hold_q = h_long; end
        PH_W_F: begin scl_q = 1'b1; hold_q = h_long; end
        PH_W_G: begin sda_q = 1'b1; hold_q = h_long; end
        PH_W_H: begin scl_q = 1'b0; hold_q = h_long; end
        PH_R_A: begin
          if (bit_cnt_q == '0) sda_q = 1'b1;
          scl_q  = 1'b0;
          hold_q = h_short;
        end
        PH_R_B: begin scl_q = 1'b1; hold_q = h_sw; end
        PH_R_C: begin scl_q = 1'b0; sda_q = 1'b1; hold_q = h_long; end
        PH_R_D: begin sda_q = 1'b0; hold_q = h_long; end
        PH_R_E: begin scl_q = 1'b1; hold_q = h_long; end
        PH_R_F: begin scl_q = 1'b0; hold_q = h_long; end
        PH_R_G: begin sda_q = 1'b1; hold_q = '0; end
        default: begin phase_q = PH_IDLE; hold_q = '0; end
      endcase
    endfunction

    // Move on to the next action; returns 1 when the sequence has ended.
    function bit next_phase(logic sda_line);
      phase_e nxt;
      nxt = PH_IDLE;
      case (phase_q)
        PH_S_A: nxt = PH_S_B;
        PH_P_A: nxt = PH_P_B;
        PH_P_B: nxt = PH_P_C;
        PH_W_A: nxt = PH_W_B;
        PH_W_B: nxt = PH_W_C;
        PH_W_C: begin
          shift_q   = shift_q << 1;
          bit_cnt_q = bit_cnt_q + 4'd1;
          nxt = (bit_cnt_q >= BitsPerByte) ? PH_W_D : PH_W_A;
        end
        PH_W_D: nxt = PH_W_E;
        PH_W_E: nxt = PH_W_F;
        PH_W_F: nxt = PH_W_G;
        PH_W_G: begin ack_q = ~sda_line; nxt = PH_W_H; end
        PH_R_A: nxt = PH_R_B;
        PH_R_B: begin
          shift_q   = {shift_q[6:0], sda_line};
          bit_cnt_q = bit_cnt_q + 4'd1;
          if (bit_cnt_q >= BitsPerByte) begin
            last_read_q = shift_q;
            nxt = PH_R_C;
          end else begin
            nxt = PH_R_A;
          end
        end
        PH_R_C: nxt = want_ack_q ? PH_R_D : PH_R_E;
        PH_R_D: nxt = PH_R_E;
        PH_R_E: nxt = PH_R_F;
        PH_R_F: nxt = PH_R_G;
        default: begin
          phase_q = PH_IDLE;
          hold_q  = '0;
          return 1'b1;
        end
      endcase
      load_phase(nxt);
      return 1'b0;
    endfunction

    // An input beat has been accepted: step the sequencer and note the result.
    function void accept_command(logic [2:0] mode, logic [7:0] data, logic ack,
                                 logic sda_line);
      line_beat_t levels;
      logic       fin;
      fin = 1'b0;
      if (phase_q == PH_IDLE) begin
        if (mode <= MODE_READ) begin
          bit_cnt_q = '0;
          case (mode)
            MODE_START: load_phase(PH_S_A);
            MODE_STOP:  load_phase(PH_P_A);
            MODE_WRITE: begin shift_q = data; load_phase(PH_W_A); end
            default: begin
              shift_q    = '0;
              want_ack_q = ack;
              load_phase(PH_R_A);
            end
          endcase
        end
      end else if (hold_q != '0) begin
        hold_q = hold_q - 17'd1;
      end else begin
        fin = next_phase(sda_line);
      end
      levels.scl     = scl_q;
      levels.sda     = sda_q;
      levels.busy    = (phase_q != PH_IDLE);
      levels.done    = fin;
      levels.ack     = ack_q;
      levels.rd_byte = last_read_q;
      line_levels_q.push_back(levels);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(line_beat_t got);
      line_beat_t want;
      if (line_levels_q.size() == 0) begin
        $error("result beat arrived with no input beat outstanding");
        errors++;
        return;
      end
      want = line_levels_q.pop_front();
      compare_field("scl_out", 8'(want.scl), 8'(got.scl));
      compare_field("sda_out", 8'(want.sda), 8'(got.sda));
      compare_field("busy_res", 8'(want.busy), 8'(got.busy));
      compare_field("done_res", 8'(want.done), 8'(got.done));
      compare_field("ack_seen", 8'(want.ack), 8'(got.ack));
      compare_field("read_data", want.rd_byte, got.rd_byte);
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [2:0] mode_i = MODE_TICK;
  logic [7:0] data_byte_i = '0;
  logic       send_ack_i = 1'b0;
  logic       sda_in_i = 1'b1;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       scl_out_o;
  logic       sda_out_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic       ack_seen_o;
  logic [7:0] read_data_o;
  logic       cfg_we_i = 1'b0;
  cfg_idx_e   cfg_idx_i = CFG_SHORT_TICKS;
  logic [15:0] cfg_wdata_i = '0;

  i2c_line_tracker lines;
  line_beat_t      seen_beat;
  int              tx_idle_pct = 27;
  int              rx_idle_pct = 59;
  bit              hold_off_req = 1'b0;
  int unsigned     items_done = 0;
  int              stall_cycles = 0;

  i2c_master_byte_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .send_ack_i  (send_ack_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .ack_seen_o  (ack_seen_o),
    .read_data_o (read_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Result side: ready is redrawn every cycle from the current idle rate. When
  // a hold-off is requested, ready stays low for a long stretch so that the
  // output register fills and the block stops taking input beats.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Every result beat is compared with the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      seen_beat.scl     = scl_out_o;
      seen_beat.sda     = sda_out_o;
      seen_beat.busy    = busy_res_o;
      seen_beat.done    = done_res_o;
      seen_beat.ack     = ack_seen_o;
      seen_beat.rd_byte = read_data_o;
      lines.check_beat(seen_beat);
    end
  end

  // Watchdog: a run in which neither channel moves for too long has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("tb_i2c_master_byte_engine: errors");
      $finish;
    end
  end

  function automatic logic pick_sda(int pol);
    if (pol == SdaRandom) return 1'($urandom_range(1));
    return (pol == SdaHigh);
  endfunction

  // Offer one input beat, after a random gap, and hold it until it is taken.
  // The line model is stepped in this process, so the next choice of beat
  // already sees the state the block is in.
  task automatic drive_item(input logic [2:0] mode, input logic [7:0] data,
                            input logic ack, input logic sda_line);
    bit counted;
    counted = lines.busy() || (mode <= MODE_READ);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    data_byte_i <= data;
    send_ack_i  <= ack;
    sda_in_i    <= sda_line;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    lines.accept_command(mode, data, ack, sda_line);
    if (counted) items_done++;
  endtask

  // Stop offering until every outstanding result beat has been seen.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (lines.pending() != 0);
  endtask

  // Feed ticks until the running command has finished. Now and then a command
  // or an undecoded mode lands in the middle, which the block must treat as a
  // plain tick, and once in a while the sender pauses until all is drained.
  task automatic finish_sequence(input int sda_pol, input int intrude_pct);
    while (lines.busy()) begin
      if (intrude_pct != 0 && $urandom_range(199) == 0) wait_drained();
      if ($urandom_range(99) < intrude_pct) begin
        drive_item(3'($urandom_range(ModeUnusedHi)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), pick_sda(sda_pol));
      end else begin
        drive_item(MODE_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   pick_sda(sda_pol));
      end
    end
  endtask

  task automatic run_command(input logic [2:0] mode, input logic [7:0] data,
                             input logic ack, input int sda_pol, input int intrude_pct);
    drive_item(mode, data, ack, pick_sda(sda_pol));
    finish_sequence(sda_pol, intrude_pct);
  endtask

  // Write all three delay registers back to back; only called when drained.
  task automatic configure(input logic [15:0] short_v, input logic [15:0] long_v,
                           input logic [15:0] wait_v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SHORT_TICKS;
    cfg_wdata_i <= short_v;
    @(posedge clk_i);
    lines.set_reg(CFG_SHORT_TICKS, short_v);
    cfg_idx_i   <= CFG_LONG_TICKS;
    cfg_wdata_i <= long_v;
    @(posedge clk_i);
    lines.set_reg(CFG_LONG_TICKS, long_v);
    cfg_idx_i   <= CFG_WAIT_TICKS;
    cfg_wdata_i <= wait_v;
    @(posedge clk_i);
    lines.set_reg(CFG_WAIT_TICKS, wait_v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly whole commands with random content, mixed with undecoded modes and
  // ticks while idle, and the odd pause until everything has drained. Every
  // command runs to its end, so the sequencer is idle when this returns.
  task automatic random_traffic(input int unsigned n_items);
    int unsigned goal;
    int          r;
    logic [2:0]  m;
    goal = items_done + n_items;
    while (items_done < goal) begin
      r = $urandom_range(99);
      if (r < 2) begin
        wait_drained();
      end else if (r < 10) begin
        drive_item(3'($urandom_range(ModeUnusedHi, MODE_TICK)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        r = $urandom_range(99);
        if (r < 18) m = MODE_START;
        else if (r < 32) m = MODE_STOP;
        else if (r < 68) m = MODE_WRITE;
        else m = MODE_READ;
        run_command(m, 8'($urandom_range(255)), 1'($urandom_range(1)), SdaRandom, 5);
      end
    end
  endtask

  initial begin
    lines = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset delays. Ticks and undecoded modes while
    // idle must leave everything as it is.
    drive_item(MODE_TICK, 8'hFF, 1'b1, 1'b0);
    for (int m = ModeUnusedLo; m <= ModeUnusedHi; m++) begin
      drive_item(3'(m), 8'h00, 1'b0, 1'b1);
    end
    run_command(MODE_START, 8'h00, 1'b0, SdaLow, 0);
    // All-zero byte acknowledged by the slave, all-ones byte not acknowledged.
    run_command(MODE_WRITE, 8'h00, 1'b0, SdaLow, 0);
    run_command(MODE_WRITE, 8'hFF, 1'b1, SdaHigh, 0);
    // Reads of all ones with ACK driven and of all zeros left as NACK.
    run_command(MODE_READ, 8'h00, 1'b1, SdaHigh, 0);
    run_command(MODE_READ, 8'hFF, 1'b0, SdaLow, 0);
    // Commands and undecoded modes arriving while a write is under way.
    drive_item(MODE_WRITE, 8'hA5, 1'b0, 1'b1);
    drive_item(MODE_START, 8'h00, 1'b1, 1'b0);
    drive_item(MODE_READ, 8'h3C, 1'b1, 1'b1);
    drive_item(ModeUnusedHi, 8'h5A, 1'b0, 1'b0);
    finish_sequence(SdaRandom, 0);
    run_command(MODE_STOP, 8'h00, 1'b0, SdaHigh, 0);

    // Zero delays: every action takes a single beat. The result side starts
    // with a long hold-off while the sender keeps offering beats.
    tx_idle_pct = 27;
    rx_idle_pct = 59;
    wait_drained();
    configure(16'd0, 16'd0, 16'd0);
    hold_off_req = 1'b1;
    random_traffic(460);

    tx_idle_pct = 59;
    rx_idle_pct = 27;
    wait_drained();
    configure(16'($urandom_range(4, 1)), 16'($urandom_range(9, 2)),
              16'($urandom_range(3)));
    random_traffic(460);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_drained();
    configure(16'($urandom_range(3)), 16'($urandom_range(6)), 16'($urandom_range(6, 2)));
    random_traffic(460);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (lines.errors == 0) begin
      $display("tb_i2c_master_byte_engine: clean");
    end else begin
      $display("tb_i2c_master_byte_engine: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/i2cmbe_pkg.sv
hw/rtl/i2c_master_byte_engine.sv
tb/tb_i2c_master_byte_engine.sv
